/* src/vertex_rotate_project_macros.svh */
// Assertion macros shared by the checker of vertex_rotate_project.
// No dependencies; expects clk and rst_n in scope.
`ifndef VERTEX_ROTATE_PROJECT_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_MACROS_SVH

// checked only while out of reset
`define VRP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vertex_rotate_project assertion failed");

// checked on every edge, reset included
`define VRP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vertex_rotate_project assertion failed");

`endif

/* src/vrp_pkg.sv */
// Types, constants and saturation helpers for vertex_rotate_project.
// No dependencies.
package vrp_pkg;

  localparam int CoordW = 24;
  localparam int TrigW  = 16;
  localparam int PixW   = 16;
  localparam int WorkW  = 48;

  typedef enum logic [2:0] {
    CFG_AXIS_X  = 3'd0,
    CFG_AXIS_Y  = 3'd1,
    CFG_AXIS_Z  = 3'd2,
    CFG_SCALE   = 3'd3,
    CFG_OFF_X   = 3'd4,
    CFG_OFF_Y   = 3'd5,
    CFG_DEPTH   = 3'd6
  } cfg_idx_t;

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [WorkW-1:0] v);
    logic signed [WorkW-1:0] hi;
    logic signed [WorkW-1:0] lo;
    hi = WorkW'(8388607);
    lo = -WorkW'(8388608);
    if (v > hi) return CoordW'(hi);
    if (v < lo) return CoordW'(lo);
    return v[CoordW-1:0];
  endfunction

  function automatic logic signed [PixW-1:0] sat_pix(input logic signed [WorkW-1:0] v);
    logic signed [WorkW-1:0] hi;
    logic signed [WorkW-1:0] lo;
    hi = WorkW'(32767);
    lo = -WorkW'(32768);
    if (v > hi) return PixW'(hi);
    if (v < lo) return PixW'(lo);
    return v[PixW-1:0];
  endfunction

endpackage

/* src/vertex_rotate_project.sv */
// Vertex rotation (X, Y, Z) and perspective projection, fully pipelined.
// Depends on vrp_pkg.
//
// Usage:
//   in_*   : one vertex per word, tdata = {coord_z, coord_y, coord_x}, tlast = last_in.
//   out_*  : one result per vertex, tdata = {depth, screen_y, screen_x}, tlast = last_out.
//   cfg_*  : register writes (index, data), always ready; write only when the
//            pipeline is empty.
// Throughput: one vertex per cycle while out_tready does not stall the pipeline.
// Pipeline: input register, six rotation stages, two projection setup
//   stages, one restoring divider stage per quotient bit, output register.
// Reset: all valid bits clear, registers take their reset values
//   (identity rotation, zero scale and offsets).
// Stall: when out_tready is low with a result held, the whole pipeline holds
//   and in_tready drops; nothing is lost or repeated.
module vertex_rotate_project #(
  parameter int COORD_FRAC_BITS = 12,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // coord_x[23:0], coord_y[47:24], coord_z[71:48]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // screen_x[15:0], screen_y[31:16], depth[55:32]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW    = vrp_pkg::CoordW;
  localparam int WW    = vrp_pkg::WorkW;
  localparam int PW    = 41;          // coord * scale
  localparam int NUM_W = 41;          // 2|n| + d
  localparam int DEN_W = 25;          // 2d
  localparam int NST   = 10 + NUM_W;  // valid stages incl. output

  // cosine 1.0, sine 0
  localparam logic [31:0] SC_RESET = {16'h0, 16'(1 << TRIG_FRAC_BITS)};

  // ---------------- configuration ----------------
  logic [31:0]          sc_r [3];
  logic [15:0]          scale_r;
  logic signed [15:0]   offx_r, offy_r;
  logic signed [CW-1:0] doff_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r[0] <= SC_RESET;
      sc_r[1] <= SC_RESET;
      sc_r[2] <= SC_RESET;
      scale_r <= '0;
      offx_r  <= '0;
      offy_r  <= '0;
      doff_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vrp_pkg::CFG_AXIS_X: sc_r[0] <= cfg_data;
        vrp_pkg::CFG_AXIS_Y: sc_r[1] <= cfg_data;
        vrp_pkg::CFG_AXIS_Z: sc_r[2] <= cfg_data;
        vrp_pkg::CFG_SCALE:  scale_r <= cfg_data[15:0];
        vrp_pkg::CFG_OFF_X:  offx_r  <= cfg_data[15:0];
        vrp_pkg::CFG_OFF_Y:  offy_r  <= cfg_data[15:0];
        vrp_pkg::CFG_DEPTH:  doff_r  <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic           en;
  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST-1:0] last_r;

  assign en        = !vld_r[NST-1] || out_tready;
  assign in_tready = en;
  assign vld_nxt   = {vld_r[NST-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) last_r <= {last_r[NST-2:0], in_tlast};
  end

  // ---------------- rotation ----------------
  // Stage 0: input. Stage 2k+1: products of axis k. Stage 2k+2: rotated vertex.
  logic signed [CW-1:0] x_r [7];
  logic signed [CW-1:0] y_r [7];
  logic signed [CW-1:0] z_r [7];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= in_tdata[23:0];
      y_r[0] <= in_tdata[47:24];
      z_r[0] <= in_tdata[71:48];
    end
  end

  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [PW:0] s);
    logic signed [WW-1:0] w;
    w = WW'(s) + (WW'(1) <<< (TRIG_FRAC_BITS - 1));
    w = w >>> TRIG_FRAC_BITS;
    return vrp_pkg::sat_coord(w);
  endfunction

  for (genvar k = 0; k < 3; k++) begin : g_rot
    logic signed [16:0]    cs, sn;
    logic signed [CW-1:0]  a, b;
    logic signed [PW-1:0]  pac_r, pbs_r, pas_r, pbc_r;
    logic signed [PW:0]    ta, tb;

    assign cs = 17'($signed(sc_r[k][15:0]));
    // Y axis runs with the sine negated so all three share one form
    assign sn = (k == 1) ? -17'($signed(sc_r[k][31:16])) : 17'($signed(sc_r[k][31:16]));
    assign a  = (k == 0) ? y_r[2*k] : x_r[2*k];
    assign b  = (k == 2) ? y_r[2*k] : z_r[2*k];

    always_ff @(posedge clk) begin
      if (en) begin
        pac_r      <= a * cs;
        pbs_r      <= b * sn;
        pas_r      <= a * sn;
        pbc_r      <= b * cs;
        x_r[2*k+1] <= x_r[2*k];
        y_r[2*k+1] <= y_r[2*k];
        z_r[2*k+1] <= z_r[2*k];
      end
    end

    assign ta = (PW+1)'(pac_r) - (PW+1)'(pbs_r);
    assign tb = (PW+1)'(pas_r) + (PW+1)'(pbc_r);

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[2*k+2] <= (k == 0) ? x_r[2*k+1] : rnd_sat(ta);
        y_r[2*k+2] <= (k == 0) ? rnd_sat(ta) : ((k == 2) ? rnd_sat(tb) : y_r[2*k+1]);
        z_r[2*k+2] <= (k == 2) ? z_r[2*k+1] : rnd_sat(tb);
      end
    end
  end

  // ---------------- projection setup ----------------
  localparam logic signed [CW-1:0] ZC_MIN = -CW'(3 <<< COORD_FRAC_BITS);

  logic signed [CW-1:0] dep_p1_r, zc_p1_r;
  logic signed [PW-1:0] nx_p1_r, ny_p1_r;
  logic signed [16:0]   scale_s;

  assign scale_s = $signed({1'b0, scale_r});

  always_ff @(posedge clk) begin
    if (en) begin
      dep_p1_r <= vrp_pkg::sat_coord(WW'(z_r[6]) + WW'(doff_r));
      zc_p1_r  <= (z_r[6] < ZC_MIN) ? z_r[6] : ZC_MIN;
      nx_p1_r  <= x_r[6] * scale_s;
      ny_p1_r  <= y_r[6] * scale_s;
    end
  end

  // ---------------- divider lanes ----------------
  // Divisor is always negative: quotient is negative when the numerator is positive.
  logic [DEN_W-2:0] dmag;
  assign dmag = (DEN_W-1)'(-WW'(zc_p1_r));

  logic signed [CW-1:0] dep_r [NUM_W+1];
  logic [DEN_W-1:0]     den_r [NUM_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dep_r[0] <= dep_p1_r;
      den_r[0] <= {dmag, 1'b0};
    end
  end

  for (genvar j = 0; j < NUM_W; j++) begin : g_dstage
    always_ff @(posedge clk) begin
      if (en) begin
        dep_r[j+1] <= dep_r[j];
        den_r[j+1] <= den_r[j];
      end
    end
  end

  logic [NUM_W-1:0] qx, qy;
  logic             negx, negy;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [NUM_W-1:0] num_r [NUM_W+1];
    logic [DEN_W-1:0] rem_r [NUM_W+1];
    logic [NUM_W-1:0] q_r   [NUM_W+1];
    logic             neg_r [NUM_W+1];
    logic signed [PW-1:0] n;
    logic [PW-1:0]        nmag;

    assign n    = (l == 0) ? nx_p1_r : ny_p1_r;
    assign nmag = n[PW-1] ? PW'(-n) : PW'(n);

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[0] <= NUM_W'({nmag, 1'b0}) + NUM_W'(dmag);
        rem_r[0] <= '0;
        q_r[0]   <= '0;
        neg_r[0] <= !n[PW-1];
      end
    end

    for (genvar j = 0; j < NUM_W; j++) begin : g_bit
      logic [DEN_W:0] r2;
      logic           ge;
      assign r2 = {rem_r[j], num_r[j][NUM_W-1-j]};
      assign ge = r2 >= {1'b0, den_r[j]};
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[j+1] <= num_r[j];
          rem_r[j+1] <= ge ? DEN_W'(r2 - {1'b0, den_r[j]}) : DEN_W'(r2);
          q_r[j+1]   <= {q_r[j][NUM_W-2:0], ge};
          neg_r[j+1] <= neg_r[j];
        end
      end
    end

    if (l == 0) begin : g_ox
      assign qx   = q_r[NUM_W];
      assign negx = neg_r[NUM_W];
    end else begin : g_oy
      assign qy   = q_r[NUM_W];
      assign negy = neg_r[NUM_W];
    end
  end

  // ---------------- output register ----------------
  logic signed [WW-1:0] sx_w, sy_w;
  logic [55:0]          out_r;

  assign sx_w = (negx ? -WW'(qx) : WW'(qx)) + WW'(offx_r);
  assign sy_w = (negy ? -WW'(qy) : WW'(qy)) + WW'(offy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= {dep_r[NUM_W], vrp_pkg::sat_pix(sy_w), vrp_pkg::sat_pix(sx_w)};
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = out_r;
  assign out_tlast  = last_r[NST-1];

endmodule

/* src/vrp_checker.sv */
// Port-level checker for vertex_rotate_project, bound to the top level.
// Depends on vertex_rotate_project_macros.svh.
`include "vertex_rotate_project_macros.svh"

module vrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  // held result stays put while the sink stalls
  `VRP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // input side stalls exactly when a result is held back
  `VRP_ASSERT(a_in_ready, in_tready == (!out_tvalid || out_tready))
  // reset empties the pipeline
  `VRP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid)

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
